// ===== rtl/assert_macros.svh =====
// assertion helpers, clocked on clk and held off during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MJAT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define MJAT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/mjat_pkg.sv =====
`timescale 1ns / 1ps
package mjat_pkg;

  localparam int NUM_JOINTS_DEF  = 6;
  localparam int MAX_SAMPLES_DEF = 64;
  localparam int NUM_LINKS       = 6;

  // datapath width of the shared serial units
  localparam int DW = 64;

  localparam int ANGLE_W  = 16;
  localparam int ACC_W    = 32;
  localparam int MOM_W    = 16;
  localparam int MSUM_W   = 19;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_MODEL_LINKS = 3'd0,
    REG_MOMENT_0    = 3'd1,
    REG_MOMENT_1    = 3'd2,
    REG_MOMENT_2    = 3'd3,
    REG_MOMENT_3    = 3'd4,
    REG_MOMENT_4    = 3'd5,
    REG_MOMENT_5    = 3'd6,
    REG_NONE        = 3'd7
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [16:0] {
    ST_IDLE  = 17'b00000000000000001,
    ST_M2    = 17'b00000000000000010,
    ST_M3    = 17'b00000000000000100,
    ST_M5    = 17'b00000000000001000,
    ST_DD    = 17'b00000000000010000,
    ST_DEN   = 17'b00000000000100000,
    ST_POLY  = 17'b00000000001000000,
    ST_K3    = 17'b00000000010000000,
    ST_PNUM  = 17'b00000000100000000,
    ST_PPROD = 17'b00000001000000000,
    ST_PDIV  = 17'b00000010000000000,
    ST_QA    = 17'b00000100000000000,
    ST_QB    = 17'b00001000000000000,
    ST_AN1   = 17'b00010000000000000,
    ST_AN2   = 17'b00100000000000000,
    ST_ADIV  = 17'b01000000000000000,
    ST_EMIT  = 17'b10000000000000000
  } state_t;

  // handshake between sequencer and a serial unit
  typedef struct packed {
    logic start;
  } unit_req_t;

  typedef struct packed {
    logic done;
  } unit_rsp_t;

endpackage

// ===== rtl/mjat_mul.sv =====
`timescale 1ns / 1ps
module mjat_mul (
  input  logic                    clk,
  input  logic                    rst,
  input  mjat_pkg::unit_req_t     req,
  input  logic [mjat_pkg::DW-1:0] a,
  input  logic [mjat_pkg::DW-1:0] b,
  output mjat_pkg::unit_rsp_t     rsp,
  output logic [mjat_pkg::DW-1:0] prod
);
  import mjat_pkg::*;

  logic [DW-1:0] mcand;
  logic [DW-1:0] mplier;
  logic          run;

  // shift-add, one multiplier bit a cycle, stops once remaining bits are zero
  always_ff @(posedge clk) begin
    if (rst) begin
      run      <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        prod   <= '0;
        mcand  <= a;
        mplier <= b;
        run    <= 1'b1;
      end else if (run) begin
        if (mplier == '0) begin
          run      <= 1'b0;
          rsp.done <= 1'b1;
        end else begin
          if (mplier[0]) begin
            prod <= prod + mcand;
          end
          mcand  <= {mcand[DW-2:0], 1'b0};
          mplier <= {1'b0, mplier[DW-1:1]};
        end
      end
    end
  end

endmodule

// ===== rtl/mjat_div.sv =====
`timescale 1ns / 1ps
module mjat_div (
  input  logic                    clk,
  input  logic                    rst,
  input  mjat_pkg::unit_req_t     req,
  input  logic [mjat_pkg::DW-1:0] num,
  input  logic [mjat_pkg::DW-1:0] den,
  output mjat_pkg::unit_rsp_t     rsp,
  output logic [mjat_pkg::DW-1:0] quo
);
  import mjat_pkg::*;

  localparam int CW = $clog2(DW);

  logic [DW-1:0] rem;
  logic [CW-1:0] cnt;
  logic          run;
  logic [DW:0]   rem_sh;
  logic [DW+1:0] diff;
  logic          qbit;

  // restoring division, one quotient bit a cycle
  always_comb begin
    rem_sh = {rem, quo[DW-1]};
    diff   = {1'b0, rem_sh} - {2'b00, den};
    qbit   = ~diff[DW+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run      <= 1'b0;
      rsp.done <= 1'b0;
      cnt      <= '0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        rem <= '0;
        quo <= num;
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        rem <= qbit ? diff[DW-1:0] : rem_sh[DW-1:0];
        quo <= {quo[DW-2:0], qbit};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DW - 1)) begin
          run      <= 1'b0;
          rsp.done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/min_jerk_accel_torque_profile.sv =====
`timescale 1ns / 1ps
// channel   direction  handshake              payload
// request   in         in_valid / in_stall    joint_index start_angle goal_angle duration_ms
//                                             sample_count
// sample    out        out_valid / out_stall  out_joint sample_index position acceleration
//                                             torque last
// config    in         cfg_we                 cfg_index cfg_data
//
// each sample runs eight shift-add multiplies and two divisions besides its
// polynomial terms and torque hand-off; a multiply runs longer the more
// significant bits its multiplier operand holds
// setup before the first sample runs the per-request multiplies; a request of n
// samples takes n sample times plus setup, longer while out_stall holds a sample back
// a request is taken only while the sequencer is idle; the last sample may still wait
// in the output register when the next request is taken
// rst is synchronous and clears control state and the configuration registers
`include "assert_macros.svh"
module min_jerk_accel_torque_profile #(
  parameter int NUM_JOINTS  = mjat_pkg::NUM_JOINTS_DEF,
  parameter int MAX_SAMPLES = mjat_pkg::MAX_SAMPLES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  joint_index,
  input  logic signed [15:0] start_angle,
  input  logic signed [15:0] goal_angle,
  input  logic [15:0] duration_ms,
  input  logic [7:0]  sample_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_joint,
  output logic [5:0]  sample_index,
  output logic signed [15:0] position,
  output logic signed [31:0] acceleration,
  output logic [31:0] torque,
  output logic        last
);
  import mjat_pkg::*;

  // configuration registers
  logic [2:0]       model_links;
  logic [MOM_W-1:0] link_moment [NUM_LINKS];

  // held request
  state_t            state;
  logic              issued;
  logic [2:0]        held_joint;
  logic signed [15:0] held_start;
  logic              dq_neg;
  logic [16:0]       adq;
  logic [15:0]       held_duration;
  logic [5:0]        held_m;
  logic [MSUM_W-1:0] msum;

  // per request products
  logic [11:0] m2;
  logic [17:0] m3;
  logic [29:0] m5;
  logic [31:0] dd;
  logic [49:0] aden;

  // per sample values
  logic [5:0]  k;
  logic [11:0] k2;
  logic [16:0] poly;
  logic [11:0] q1;
  logic [6:0]  amk2;
  logic        mk2_neg;
  logic [DW-1:0] t_reg;
  logic [16:0] pmag;
  logic [31:0] amag;
  logic        a_neg;

  // shared serial units
  unit_req_t     mul_req, div_req;
  unit_rsp_t     mul_rsp, div_rsp;
  logic [DW-1:0] mul_a, mul_b, mul_p;
  logic [DW-1:0] div_n, div_d, div_q;

  mjat_mul u_mul (
    .clk (clk), .rst (rst), .req (mul_req), .a (mul_a), .b (mul_b),
    .rsp (mul_rsp), .prod (mul_p)
  );

  mjat_div u_div (
    .clk (clk), .rst (rst), .req (div_req), .num (div_n), .den (div_d),
    .rsp (div_rsp), .quo (div_q)
  );

  logic in_accept;
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid & ~in_stall;

  // request decode
  logic [2:0]        links_c;
  logic [MSUM_W-1:0] msum_c;
  logic [7:0]        n_c;
  logic signed [16:0] dq_c;

  always_comb begin
    links_c = (model_links > 3'(NUM_LINKS)) ? 3'(NUM_LINKS) : model_links;
    msum_c  = '0;
    for (int j = 0; j < NUM_LINKS; j++) begin
      if ((3'(j) >= joint_index) && (3'(j) < links_c)) begin
        msum_c = msum_c + MSUM_W'(link_moment[j]);
      end
    end
    if (sample_count < 8'd2) begin
      n_c = 8'd2;
    end else if (sample_count > 8'(MAX_SAMPLES)) begin
      n_c = 8'(MAX_SAMPLES);
    end else begin
      n_c = sample_count;
    end
    dq_c = 17'(goal_angle) - 17'(start_angle);
  end

  // sample polynomial terms, small enough to compute combinationally
  logic [11:0] k2_c, km_c, q1_c;
  logic [16:0] poly_c;
  logic [6:0]  k2x_c;

  always_comb begin
    k2_c   = 12'(k) * 12'(k);
    km_c   = 12'(k) * 12'(held_m);
    q1_c   = 12'(k) * 12'(held_m - k);
    poly_c = 17'd10 * 17'(m2) + 17'd6 * 17'(k2_c) - 17'd15 * 17'(km_c);
    k2x_c  = {k, 1'b0};
  end

  // operand selection for the serial units
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    div_n = '0;
    div_d = '0;
    case (state)
      ST_M2:    begin mul_a = DW'(held_m); mul_b = DW'(held_m); end
      ST_M3:    begin mul_a = DW'(m2);     mul_b = DW'(held_m); end
      ST_M5:    begin mul_a = DW'(m3);     mul_b = DW'(m2);     end
      ST_DD:    begin mul_a = DW'(held_duration); mul_b = DW'(held_duration); end
      ST_DEN:   begin mul_a = DW'(dd);     mul_b = DW'(m3);     end
      ST_K3:    begin mul_a = DW'(k2);     mul_b = DW'(k);      end
      ST_PNUM:  begin mul_a = t_reg;       mul_b = DW'(poly);   end
      ST_PPROD: begin mul_a = t_reg;       mul_b = DW'(adq);    end
      ST_QA:    begin mul_a = DW'(q1);     mul_b = DW'(amk2);   end
      ST_QB:    begin mul_a = t_reg;       mul_b = DW'(60);     end
      ST_AN1:   begin mul_a = t_reg;       mul_b = DW'(adq);    end
      ST_AN2:   begin mul_a = t_reg;       mul_b = DW'(16000000); end
      ST_EMIT:  begin mul_a = DW'(amag);   mul_b = DW'(msum);   end
      ST_PDIV:  begin div_n = t_reg + DW'(m5 >> 1);   div_d = DW'(m5);   end
      ST_ADIV:  begin div_n = t_reg + DW'(aden >> 1); div_d = DW'(aden); end
      default:  begin mul_a = '0; end
    endcase
  end

  logic is_div_st, is_mul_st;
  assign is_div_st     = (state == ST_PDIV) || (state == ST_ADIV);
  assign is_mul_st     = ~is_div_st && (state != ST_IDLE) && (state != ST_POLY);
  assign mul_req.start = is_mul_st && ~issued;
  assign div_req.start = is_div_st && ~issued;

  // result shaping
  logic               unit_done;
  logic signed [17:0] pos_c;
  logic signed [15:0] pos_sat;
  logic               a_neg_c;
  logic [31:0]        amag_c;
  logic [DW-1:0]      tsum_c;
  logic [31:0]        tq_c;
  logic signed [31:0] acc_c;
  logic               out_free;
  logic               tq_ready;
  logic               emit_now;

  always_comb begin
    unit_done = mul_rsp.done | div_rsp.done;
    pos_c = 18'(held_start) + (dq_neg ? -$signed({1'b0, pmag}) : $signed({1'b0, pmag}));
    if (pos_c > 18'sd32767) begin
      pos_sat = 16'sh7FFF;
    end else if (pos_c < -18'sd32768) begin
      pos_sat = 16'sh8000;
    end else begin
      pos_sat = pos_c[15:0];
    end
    a_neg_c = dq_neg ^ mk2_neg;
    if (a_neg_c) begin
      amag_c = (div_q > DW'(32'h8000_0000)) ? 32'h8000_0000 : div_q[31:0];
    end else begin
      amag_c = (div_q > DW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : div_q[31:0];
    end
    acc_c  = a_neg ? -$signed(amag) : $signed(amag);
    tsum_c = mul_p + DW'(128);
    tq_c   = (|tsum_c[DW-1:40]) ? 32'hFFFF_FFFF : tsum_c[39:8];
    out_free = ~out_valid | ~out_stall;
  end

  // a sample leaves once its torque is in and the output register is free
  assign emit_now = (state == ST_EMIT) && tq_ready && out_free;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      model_links <= 3'd6;
      for (int j = 0; j < NUM_LINKS; j++) begin
        link_moment[j] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MODEL_LINKS: model_links    <= cfg_data[2:0];
        REG_MOMENT_0:    link_moment[0] <= cfg_data;
        REG_MOMENT_1:    link_moment[1] <= cfg_data;
        REG_MOMENT_2:    link_moment[2] <= cfg_data;
        REG_MOMENT_3:    link_moment[3] <= cfg_data;
        REG_MOMENT_4:    link_moment[4] <= cfg_data;
        REG_MOMENT_5:    link_moment[5] <= cfg_data;
        default:         model_links    <= model_links;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      issued    <= 1'b0;
      out_valid <= 1'b0;
      k         <= '0;
    end else begin
      if (out_valid && !out_stall && !emit_now) begin
        out_valid <= 1'b0;
      end
      if (mul_req.start || div_req.start) begin
        issued <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          // requests for joints beyond the table are taken and dropped
          if (in_accept && (32'(joint_index) < NUM_JOINTS)) begin
            held_joint    <= joint_index;
            held_start    <= start_angle;
            dq_neg        <= dq_c[16];
            adq           <= dq_c[16] ? 17'(-dq_c) : 17'(dq_c);
            held_duration <= (duration_ms == 16'd0) ? 16'd1 : duration_ms;
            held_m        <= 6'(n_c - 8'd1);
            msum          <= msum_c;
            k             <= '0;
            state         <= ST_M2;
          end
        end
        ST_POLY: begin
          k2      <= k2_c;
          poly    <= poly_c;
          q1      <= q1_c;
          mk2_neg <= k2x_c > 7'(held_m);
          amk2    <= (k2x_c > 7'(held_m)) ? (k2x_c - 7'(held_m)) : (7'(held_m) - k2x_c);
          state   <= ST_K3;
        end
        ST_EMIT: begin
          // torque multiply runs first, then the sample waits for the output register
          if (mul_rsp.done) begin
            t_reg <= DW'(tq_c);
          end
          if (emit_now) begin
            out_valid    <= 1'b1;
            out_joint    <= held_joint;
            sample_index <= k;
            position     <= pos_sat;
            acceleration <= acc_c;
            torque       <= t_reg[31:0];
            last         <= (k == held_m);
            issued       <= 1'b0;
            if (k == held_m) begin
              state <= ST_IDLE;
            end else begin
              k     <= k + 6'd1;
              state <= ST_POLY;
            end
          end
        end
        default: begin
          if (issued && unit_done) begin
            issued <= 1'b0;
            t_reg  <= mul_p;
            case (state)
              ST_M2:    begin m2   <= mul_p[11:0]; state <= ST_M3;    end
              ST_M3:    begin m3   <= mul_p[17:0]; state <= ST_M5;    end
              ST_M5:    begin m5   <= mul_p[29:0]; state <= ST_DD;    end
              ST_DD:    begin dd   <= mul_p[31:0]; state <= ST_DEN;   end
              ST_DEN:   begin aden <= mul_p[49:0]; state <= ST_POLY;  end
              ST_K3:    begin state <= ST_PNUM;  end
              ST_PNUM:  begin state <= ST_PPROD; end
              ST_PPROD: begin state <= ST_PDIV;  end
              ST_PDIV:  begin pmag <= div_q[16:0]; state <= ST_QA; end
              ST_QA:    begin state <= ST_QB;    end
              ST_QB:    begin state <= ST_AN1;   end
              ST_AN1:   begin state <= ST_AN2;   end
              ST_AN2:   begin state <= ST_ADIV;  end
              ST_ADIV: begin
                amag   <= amag_c;
                a_neg  <= a_neg_c;
                state  <= ST_EMIT;
              end
              default:  begin state <= ST_IDLE;  end
            endcase
          end
        end
      endcase
    end
  end

  // the torque product is ready once the multiplier has reported back
  always_ff @(posedge clk) begin
    if (rst) begin
      tq_ready <= 1'b0;
    end else if (state != ST_EMIT) begin
      tq_ready <= 1'b0;
    end else if (mul_rsp.done) begin
      tq_ready <= 1'b1;
    end
  end

  `MJAT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(sample_index))
  `MJAT_ASSERT_NOW(a_index_range, out_valid && !in_stall && !last, 1'b0)
  `MJAT_ASSERT_NEXT(a_req_start, in_accept && (32'(joint_index) < NUM_JOINTS), state == ST_M2)

endmodule
